/* hdl/fcl_pkg.sv */
// Shared constants, codes and types for the fully connected layer.
`timescale 1ns / 1ps

package fcl_pkg;

    // Store sizes
    localparam int MAX_IN  = 64;
    localparam int MAX_OUT = 64;

    // Field and counter widths
    localparam int IDX_W   = 6;     // feature index width
    localparam int CNT_W   = 7;     // count width, holds 0..127
    localparam int SMP_W   = 16;    // Q8.8 sample
    localparam int BIAS_W  = 32;    // Q16.16 bias / activation
    localparam int PROD_W  = 32;    // Q8.8 x Q8.8 product
    localparam int ACC_W   = 48;    // accumulator
    localparam int WADDR_W = 2 * IDX_W;

    // Largest count in use
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(64);

    // Input word actions
    typedef enum logic [1:0] {
        ACT_WEIGHT = 2'd0,
        ACT_BIAS   = 2'd1,
        ACT_ROW    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Controls from the sequencer to the MAC unit
    typedef struct packed {
        logic clear;     // zero the accumulator
        logic mul_en;    // operands valid, register their product
        logic bias_en;   // add bias into the result
    } fcl_mac_ctrl_t;

endpackage

/* hdl/fully_connected_layer.sv */
// Fully connected layer forward pass: stores, sequencer and output register.
//
// Usage: input words arrive on in_valid / in_stall. action 0 loads one
// weight W[out_index][in_index], action 1 loads bias[out_index], action 2
// delivers the next element of the current input row; action 3 is dropped.
// Loads and row elements that do not finish a row are taken without a stall.
// The element that completes a row (in_count elements, or any element when
// in_count is 0) starts the computation of out_count results (counts above
// 64 act as 64), emitted in order of feature on out_valid / out_stall,
// row_done on the last one. One shared 16x16 MAC does the work: for each
// output the sequencer reads the weight/row pairs, drains the pipeline,
// then adds the bias if enabled and saturates. in_stall is high throughout.
// A finished result waits in the output register; while out_stall holds,
// the sequencer waits before writing the next one.
// Reset clears the configuration registers (in_count, out_count,
// bias_enable at byte addresses 0, 4, 8) and the row element count;
// weight, bias and row stores hold no reset value and must be loaded.
`timescale 1ns / 1ps

module fully_connected_layer (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [fcl_pkg::IDX_W-1:0]           out_index,
    input  logic [fcl_pkg::IDX_W-1:0]           in_index,
    input  logic signed [fcl_pkg::SMP_W-1:0]    sample,
    input  logic signed [fcl_pkg::BIAS_W-1:0]   bias_word,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fcl_pkg::IDX_W-1:0]           feature,
    output logic signed [fcl_pkg::BIAS_W-1:0]   activation,
    output logic                                clipped,
    output logic                                row_done
);
    import fcl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_BIAS
    } state_t;

    typedef enum logic [1:0] {
        REG_IN_COUNT    = 2'd0,
        REG_OUT_COUNT   = 2'd1,
        REG_BIAS_ENABLE = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    // Configuration registers
    logic [CNT_W-1:0] in_count_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             bias_enable_reg;
    logic             cfg_write;

    // Sequencer
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ec_reg, ec_next;
    logic [IDX_W-1:0] o_reg, o_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             rd_valid_reg, rd_valid_next;

    logic [CNT_W-1:0] ni;
    logic [CNT_W-1:0] no;
    logic [CNT_W-1:0] ni_m1;
    logic [CNT_W-1:0] ec_inc;
    logic             in_accept;
    logic             o_last;
    logic             out_free;
    logic             out_load;

    // Stores and their read registers
    logic signed [SMP_W-1:0]  weight_mem [MAX_OUT*MAX_IN];
    logic signed [BIAS_W-1:0] bias_mem   [MAX_OUT];
    logic signed [SMP_W-1:0]  row_mem    [MAX_IN];
    logic signed [SMP_W-1:0]  w_q_reg;
    logic signed [SMP_W-1:0]  x_q_reg;
    logic signed [BIAS_W-1:0] bias_q_reg;
    logic                     row_wr;

    // MAC
    fcl_mac_ctrl_t            mac_ctrl;
    logic                     mac_busy;
    logic signed [BIAS_W-1:0] mac_result;
    logic                     mac_clip;

    // Output register
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         feature_reg;
    logic signed [BIAS_W-1:0] activation_reg;
    logic                     clipped_reg;
    logic                     row_done_reg;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg    <= '0;
            out_count_reg   <= '0;
            bias_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_IN_COUNT:    in_count_reg    <= pwdata[CNT_W-1:0];
                REG_OUT_COUNT:   out_count_reg   <= pwdata[CNT_W-1:0];
                REG_BIAS_ENABLE: bias_enable_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_IN_COUNT:    prdata = 32'(in_count_reg);
            REG_OUT_COUNT:   prdata = 32'(out_count_reg);
            REG_BIAS_ENABLE: prdata = 32'(bias_enable_reg);
            default:         prdata = '0;
        endcase
    end

    // Counts in use
    assign ni     = (in_count_reg  > COUNT_LIMIT) ? COUNT_LIMIT : in_count_reg;
    assign no     = (out_count_reg > COUNT_LIMIT) ? COUNT_LIMIT : out_count_reg;
    assign ni_m1  = ni - CNT_W'(1);
    assign ec_inc = ec_reg + CNT_W'(1);
    assign o_last = ({1'b0, o_reg} == no - CNT_W'(1));

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Stores
    assign row_wr = in_accept && (action == ACT_ROW) && (ni != '0)
                    && (ec_reg < CNT_W'(MAX_IN));

    always_ff @(posedge clk)
    begin
        if (in_accept && (action == ACT_WEIGHT))
        begin
            weight_mem[{out_index, in_index}] <= sample;
        end
        w_q_reg <= weight_mem[{o_reg, j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (action == ACT_BIAS))
        begin
            bias_mem[out_index] <= bias_word;
        end
        bias_q_reg <= bias_mem[o_reg];
    end

    always_ff @(posedge clk)
    begin
        if (row_wr)
        begin
            row_mem[ec_reg[IDX_W-1:0]] <= sample;
        end
        x_q_reg <= row_mem[j_reg];
    end

    // Sequencer
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_BIAS) && out_free;

    always_comb
    begin
        state_next    = state_reg;
        ec_next       = ec_reg;
        o_next        = o_reg;
        j_next        = j_reg;
        rd_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (action == ACT_ROW))
                begin
                    if ((ni != '0) && (ec_inc < ni))
                    begin
                        ec_next = ec_inc;
                    end
                    else
                    begin
                        ec_next = '0;
                        if (no != '0)
                        begin
                            o_next     = '0;
                            j_next     = '0;
                            state_next = (ni != '0) ? S_MAC : S_DRAIN;
                        end
                    end
                end
            end
            S_MAC:
            begin
                rd_valid_next = 1'b1;
                if (j_reg == ni_m1[IDX_W-1:0])
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = S_BIAS;
                end
            end
            S_BIAS:
            begin
                if (out_free)
                begin
                    if (o_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        o_next     = o_reg + IDX_W'(1);
                        j_next     = '0;
                        state_next = (ni != '0) ? S_MAC : S_DRAIN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ec_reg         <= '0;
            o_reg          <= '0;
            j_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            feature_reg    <= '0;
            activation_reg <= '0;
            clipped_reg    <= 1'b0;
            row_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ec_reg       <= ec_next;
            o_reg        <= o_next;
            j_reg        <= j_next;
            rd_valid_reg <= rd_valid_next;
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                feature_reg    <= o_reg;
                activation_reg <= mac_result;
                clipped_reg    <= mac_clip;
                row_done_reg   <= o_last;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Shared MAC
    assign mac_ctrl.clear   = (state_reg == S_IDLE) || out_load;
    assign mac_ctrl.mul_en  = rd_valid_reg;
    assign mac_ctrl.bias_en = bias_enable_reg;

    fcl_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .x      (x_q_reg),
        .w      (w_q_reg),
        .bias   (bias_q_reg),
        .busy   (mac_busy),
        .result (mac_result),
        .clip   (mac_clip)
    );

    assign out_valid  = out_valid_reg;
    assign feature    = feature_reg;
    assign activation = activation_reg;
    assign clipped    = clipped_reg;
    assign row_done   = row_done_reg;

endmodule

/* hdl/fcl_mac.sv */
// Shared multiply-accumulate unit with bias add and 32-bit saturation.
`timescale 1ns / 1ps

module fcl_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcl_pkg::fcl_mac_ctrl_t        ctrl,
    input  logic signed [fcl_pkg::SMP_W-1:0]  x,
    input  logic signed [fcl_pkg::SMP_W-1:0]  w,
    input  logic signed [fcl_pkg::BIAS_W-1:0] bias,
    output logic                          busy,
    output logic signed [fcl_pkg::BIAS_W-1:0] result,
    output logic                          clip
);
    import fcl_pkg::*;

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  sum;
    logic                     ovf;

    // Product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(x) * PROD_W'(w);
        end
    end

    // Accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Bias add and saturation
    always_comb
    begin
        sum = acc_reg;
        if (ctrl.bias_en)
        begin
            sum = acc_reg + ACC_W'(bias);
        end
        ovf = (sum[ACC_W-1:BIAS_W-1] != '0) && (sum[ACC_W-1:BIAS_W-1] != '1);
        if (ovf)
        begin
            result = sum[ACC_W-1] ? {1'b1, {(BIAS_W-1){1'b0}}} : {1'b0, {(BIAS_W-1){1'b1}}};
        end
        else
        begin
            result = sum[BIAS_W-1:0];
        end
        clip = ovf;
    end

    assign busy = prod_valid_reg;

endmodule

/* verif/fully_connected_layer_test.sv */
// Self-checking testbench for the fully connected layer forward pass.
`timescale 1ns / 1ps

module fully_connected_layer_test;

    import fcl_pkg::*;

    // Register indexes, byte address is 4 * index
    localparam int REG_IN_COUNT    = 0;
    localparam int REG_OUT_COUNT   = 1;
    localparam int REG_BIAS_ENABLE = 2;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int LANES       = 64;

    // One result word as seen on the output channel
    typedef struct packed {
        logic [IDX_W-1:0]         feature;
        logic signed [BIAS_W-1:0] activation;
        logic                     clipped;
        logic                     row_done;
    } fc_out_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [3:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 action = ACT_NONE;
    logic [IDX_W-1:0]           out_index = '0;
    logic [IDX_W-1:0]           in_index = '0;
    logic signed [SMP_W-1:0]    sample = '0;
    logic signed [BIAS_W-1:0]   bias_word = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [IDX_W-1:0]           feature;
    logic signed [BIAS_W-1:0]   activation;
    logic                       clipped;
    logic                       row_done;

    // Shadow of the layer state
    logic signed [SMP_W-1:0]    wt_mem [MAX_OUT][MAX_IN];
    bit                         wt_loaded [MAX_OUT][MAX_IN];
    logic signed [BIAS_W-1:0]   bias_mem [MAX_OUT];
    bit                         bias_loaded [MAX_OUT];
    logic signed [SMP_W-1:0]    row_mem [MAX_IN];
    int                         row_fill = 0;
    int                         cur_in = 0;
    int                         cur_out = 0;
    bit                         cur_bias_en = 1'b0;

    fc_out_t                    pending_activations [$];
    int                         mismatch_count = 0;
    int                         cycle_count = 0;
    bit                         feed_eager = 1'b0;
    bit                         drain_eager = 1'b0;

    fully_connected_layer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .out_index  (out_index),
        .in_index   (in_index),
        .sample     (sample),
        .bias_word  (bias_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .feature    (feature),
        .activation (activation),
        .clipped    (clipped),
        .row_done   (row_done)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fully_connected_layer verification failed");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Counts beyond the store size are clipped to 64 lanes
    function automatic int lanes(input int c);
        return (c > LANES) ? LANES : c;
    endfunction

    function automatic int draw_gap(input bit eager);
        return eager ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(0, 2047) - 1024);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [BIAS_W-1:0] rand_bias();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3, 4: return 32'($urandom_range(0, 1 << 20) - (1 << 19));
            default: return 32'($urandom());
        endcase
    endfunction

    // Update the shadow state with one accepted word; queue the row's outputs
    task automatic track_word(input action_t a, input logic [IDX_W-1:0] oi,
                              input logic [IDX_W-1:0] ii, input logic signed [SMP_W-1:0] smp,
                              input logic signed [BIAS_W-1:0] bw);
        int      ni;
        int      no;
        bit      finished;
        longint  acc;
        fc_out_t r;
        ni = lanes(cur_in);
        no = lanes(cur_out);
        case (a)
            ACT_WEIGHT:
            begin
                wt_mem[oi][ii] = smp;
                wt_loaded[oi][ii] = 1'b1;
            end
            ACT_BIAS:
            begin
                bias_mem[oi] = bw;
                bias_loaded[oi] = 1'b1;
            end
            ACT_ROW:
            begin
                finished = 1'b1;
                if (ni > 0)
                begin
                    if (row_fill < MAX_IN)
                        row_mem[row_fill] = smp;
                    row_fill = (row_fill + 1) & 127;
                    finished = (row_fill >= ni);
                end
                if (finished)
                begin
                    row_fill = 0;
                    for (int o = 0; o < no; o++)
                    begin
                        acc = 0;
                        for (int j = 0; j < ni; j++)
                            acc += longint'(row_mem[j]) * longint'(wt_mem[o][j]);
                        if (cur_bias_en)
                            acc += longint'(bias_mem[o]);
                        r.clipped = 1'b0;
                        if (acc > 64'sh7FFF_FFFF)
                        begin
                            acc = 64'sh7FFF_FFFF;
                            r.clipped = 1'b1;
                        end
                        else if (acc < -64'sh8000_0000)
                        begin
                            acc = -64'sh8000_0000;
                            r.clipped = 1'b1;
                        end
                        r.feature = IDX_W'(o);
                        r.activation = 32'(acc);
                        r.row_done = (o + 1 == no);
                        pending_activations.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Output side: random stall per word, compare against oldest expectation
    always @(posedge clk)
    begin
        fc_out_t got;
        fc_out_t want;
        int      stall_left;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {feature, activation, clipped, row_done};
                if (pending_activations.size() == 0)
                    note_mismatch($sformatf("unexpected word feature=%0d act=%h",
                                            feature, activation));
                else
                begin
                    want = pending_activations.pop_front();
                    if (got !== want)
                        note_mismatch($sformatf(
                            "feature %0d/%0d act %h/%h clipped %b/%b row_done %b/%b",
                            got.feature, want.feature, got.activation, want.activation,
                            got.clipped, want.clipped, got.row_done, want.row_done));
                end
                stall_left = draw_gap(drain_eager);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // Send one word; valid stays up if the next word follows at once
    task automatic send_word(input action_t a, input logic [IDX_W-1:0] oi,
                             input logic [IDX_W-1:0] ii, input logic [SMP_W-1:0] smp,
                             input logic [BIAS_W-1:0] bw);
        int gap;
        gap = draw_gap(feed_eager);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= a;
        out_index <= oi;
        in_index  <= ii;
        sample    <= smp;
        bias_word <= bw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_word(a, oi, ii, smp, bw);
    endtask

    task automatic load_weight(input int o, input int j, input logic [SMP_W-1:0] v);
        send_word(ACT_WEIGHT, IDX_W'(o), IDX_W'(j), v, 32'($urandom()));
    endtask

    task automatic load_bias(input int o, input logic [BIAS_W-1:0] v);
        send_word(ACT_BIAS, IDX_W'(o), IDX_W'($urandom()), 16'($urandom()), v);
    endtask

    task automatic send_noise();
        send_word(ACT_NONE, IDX_W'($urandom()), IDX_W'($urandom()), 16'($urandom()),
                  32'($urandom()));
    endtask

    // Row element; loads any weight or bias the finishing row would read unloaded
    task automatic send_element(input logic [SMP_W-1:0] v);
        int ni;
        int no;
        ni = lanes(cur_in);
        no = lanes(cur_out);
        if (ni == 0 || row_fill + 1 >= ni)
        begin
            for (int o = 0; o < no; o++)
            begin
                for (int j = 0; j < ni; j++)
                    if (!wt_loaded[o][j])
                        load_weight(o, j, rand_sample());
                if (cur_bias_en && !bias_loaded[o])
                    load_bias(o, rand_bias());
            end
        end
        send_word(ACT_ROW, IDX_W'($urandom()), IDX_W'($urandom()), v, 32'($urandom()));
    endtask

    // Wait until every expected word is out and the sequencer has wound down
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_activations.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_IN_COUNT:    cur_in = int'(val[6:0]);
            REG_OUT_COUNT:   cur_out = int'(val[6:0]);
            REG_BIAS_ENABLE: cur_bias_en = val[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input int idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 4'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            note_mismatch($sformatf("register %0d read %h, want %h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int n_in, input int n_out, input bit use_bias);
        settle();
        write_reg(REG_IN_COUNT, 32'(n_in));
        write_reg(REG_OUT_COUNT, 32'(n_out));
        write_reg(REG_BIAS_ENABLE, 32'(use_bias));
    endtask

    // Reset values, all-ones and zero through each register
    task automatic test_registers();
        read_reg(REG_IN_COUNT, 32'd0);
        read_reg(REG_OUT_COUNT, 32'd0);
        read_reg(REG_BIAS_ENABLE, 32'd0);
        write_reg(REG_IN_COUNT, 32'd127);
        write_reg(REG_OUT_COUNT, 32'd127);
        write_reg(REG_BIAS_ENABLE, 32'd1);
        read_reg(REG_IN_COUNT, 32'd127);
        read_reg(REG_OUT_COUNT, 32'd127);
        read_reg(REG_BIAS_ENABLE, 32'd1);
        write_reg(REG_IN_COUNT, 32'd0);
        write_reg(REG_OUT_COUNT, 32'd0);
        write_reg(REG_BIAS_ENABLE, 32'd0);
        read_reg(REG_IN_COUNT, 32'd0);
        read_reg(REG_OUT_COUNT, 32'd0);
        read_reg(REG_BIAS_ENABLE, 32'd0);
    endtask

    // Field extremes, both saturation directions, every action and count corner
    task automatic test_corner_words();
        set_config(2, 2, 1'b1);
        load_weight(0, 0, 16'h7FFF);
        load_weight(0, 1, 16'h7FFF);
        load_weight(1, 0, 16'h8000);
        load_weight(1, 1, 16'h8000);
        load_bias(0, 32'h7FFF_FFFF);
        load_bias(1, 32'h8000_0000);
        send_noise();
        // positive clip on feature 0, negative clip on feature 1
        send_element(16'h7FFF);
        send_element(16'h7FFF);
        // most negative inputs: no clip, feature 1 lands on zero
        send_element(16'h8000);
        send_element(16'h8000);
        load_weight(63, 63, rand_sample());
        load_bias(63, rand_bias());
        // zero in_count: each element emits the bias, then zero with bias off
        set_config(0, 2, 1'b1);
        send_element(16'h1234);
        set_config(0, 2, 1'b0);
        send_element(16'hFFFF);
        // zero out_count: row is consumed silently
        set_config(2, 0, 1'b1);
        send_element(16'h0100);
        send_element(16'hFF00);
        // in_count lowered while a row is partly filled
        set_config(3, 2, 1'b0);
        send_element(16'h0200);
        set_config(1, 2, 1'b0);
        send_element(16'h0300);
    endtask

    // Widest row and widest result set, with oversized counts that clip to 64
    task automatic test_full_size();
        set_config(127, 1, 1'b1);
        for (int j = 0; j < LANES; j++)
            send_element(rand_sample());
        set_config(0, 127, 1'b0);
        send_element(rand_sample());
    endtask

    // Phases of random sizes: mostly row traffic with loads and stray words mixed in
    task automatic test_random_traffic();
        int n_in;
        int n_out;
        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 9))
                0: n_in = 0;
                1: n_in = $urandom_range(9, 127);
                default: n_in = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0: n_out = 0;
                1: n_out = $urandom_range(9, 64);
                default: n_out = $urandom_range(1, 6);
            endcase
            // keep the weight loads of one phase small
            if (n_out > 8)
                n_in = $urandom_range(0, 1);
            else if (n_in > 8)
                n_out = $urandom_range(0, 1);
            set_config(n_in, n_out, $urandom_range(0, 1));
            feed_eager = ($urandom_range(0, 3) == 0);
            drain_eager = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 14; n++)
            begin
                case ($urandom_range(0, 19))
                    0: send_noise();
                    1, 2, 3: load_weight($urandom_range(0, 63), $urandom_range(0, 63),
                                         rand_sample());
                    4: load_bias($urandom_range(0, 63), rand_bias());
                    default: send_element(rand_sample());
                endcase
            end
        end
    endtask

    // Test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_registers();
        test_corner_words();
        test_full_size();
        test_random_traffic();
        settle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("fully_connected_layer verification clean");
        else
            $display("fully_connected_layer verification failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/fcl_pkg.sv
hdl/fcl_mac.sv
hdl/fully_connected_layer.sv
verif/fully_connected_layer_test.sv
